[hdl/terminal_pixel_report_parser_assert.svh]
// Assertion macros for the pixel report parser.
`ifndef TERMINAL_PIXEL_REPORT_PARSER_ASSERT_SVH
`define TERMINAL_PIXEL_REPORT_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define TPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpr check failed");

`endif

[hdl/tpr_pkg.sv]
// Shared types and constants of the pixel report parser.
package tpr_pkg;

    localparam int CHAR_W     = 8;
    localparam int ACC_W      = 16;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 11;
    localparam int SEL_W      = 2;
    localparam int HDR_W      = 8;
    localparam int MAX_PIXELS = 1024;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_OFFSET  = 2'd2;

    localparam logic [SEL_W-1:0] COMP_LAST = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OFFSET,
        PH_SCAN1,
        PH_SKIP3,
        PH_SCAN2,
        PH_LEAD,
        PH_INT,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              start;
        logic              is_digit;
        logic              is_high;
    } q_entry_t;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic [SEL_W-1:0] channel_select;
        logic [CNT_W-1:0] pixel_count;
        logic [HDR_W-1:0] header_offset;
    } cfg_t;

endpackage

[hdl/tpr_if.sv]
// Stream and configuration interfaces of the pixel report parser.
interface tpr_char_if;
    logic                      valid;
    logic                      ready;
    logic [tpr_pkg::CHAR_W-1:0] char_in;
    logic                      start_of_report;

    modport source (output valid, output char_in, output start_of_report, input ready);
    modport sink (input valid, input char_in, input start_of_report, output ready);
endinterface

interface tpr_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [tpr_pkg::CHAR_W-1:0] pixel_value;
    logic [tpr_pkg::IDX_W-1:0]  pixel_index;
    logic                      last_pixel;

    modport source (output valid, output pixel_value, output pixel_index,
                    output last_pixel, input ready);
    modport sink (input valid, input pixel_value, input pixel_index,
                  input last_pixel, output ready);
endinterface

interface tpr_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tpr_pkg::CFG_IDX_W-1:0]  index;
    logic [tpr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/tpr_front.sv]
// Front end: accept report bytes, classify them and push them to the queue.
module tpr_front
(
    tpr_char_if.sink              char_stream,
    input  tpr_pkg::q_stat_t      q_stat,
    output logic                  q_push,
    output tpr_pkg::q_entry_t     q_entry
);

    assign char_stream.ready = !q_stat.full;
    assign q_push            = char_stream.valid && !q_stat.full;

    always_comb
    begin
        q_entry.char_in  = char_stream.char_in;
        q_entry.start    = char_stream.start_of_report;
        q_entry.is_digit = char_stream.char_in inside {[8'h30:8'h3F]};
        q_entry.is_high  = char_stream.char_in inside {[8'h40:8'h7F]};
    end

endmodule

[hdl/tpr_fifo.sv]
// Short queue between the front end and the parser.
module tpr_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tpr_pkg::q_entry_t     wr_entry,
    input  logic                  pop,
    output tpr_pkg::q_entry_t     rd_entry,
    output tpr_pkg::q_stat_t      stat
);

    tpr_pkg::q_entry_t                 mem_reg [tpr_pkg::Q_DEPTH];
    logic [tpr_pkg::Q_PTR_W-1:0]       wr_ptr_reg;
    logic [tpr_pkg::Q_PTR_W-1:0]       wr_ptr_next;
    logic [tpr_pkg::Q_PTR_W-1:0]       rd_ptr_reg;
    logic [tpr_pkg::Q_PTR_W-1:0]       rd_ptr_next;
    logic [tpr_pkg::Q_CNT_W-1:0]       count_reg;
    logic [tpr_pkg::Q_CNT_W-1:0]       count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    assign rd_entry   = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == tpr_pkg::Q_CNT_W'(tpr_pkg::Q_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

[hdl/tpr_back.sv]
// Back end: parse queued bytes and hold decoded pixels in the output register.
module tpr_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  tpr_pkg::cfg_t         cfg,
    input  tpr_pkg::q_entry_t     q_entry,
    input  tpr_pkg::q_stat_t      q_stat,
    output logic                  q_pop,
    tpr_pixel_if.source           pixel_stream
);

    tpr_pkg::phase_t                 phase_reg;
    tpr_pkg::phase_t                 phase_next;
    logic [tpr_pkg::HDR_W-1:0]       bc_reg;
    logic [tpr_pkg::HDR_W-1:0]       bc_next;
    logic [tpr_pkg::ACC_W-1:0]       acc_reg;
    logic [tpr_pkg::ACC_W-1:0]       acc_next;
    logic [tpr_pkg::SEL_W-1:0]       comp_reg;
    logic [tpr_pkg::SEL_W-1:0]       comp_next;
    logic [tpr_pkg::CNT_W-1:0]       pc_reg;
    logic [tpr_pkg::CNT_W-1:0]       pc_next;
    logic [tpr_pkg::CHAR_W-1:0]      sel_reg;
    logic [tpr_pkg::CHAR_W-1:0]      sel_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [tpr_pkg::CHAR_W-1:0]      out_value_reg;
    logic [tpr_pkg::IDX_W-1:0]       out_index_reg;
    logic                            out_last_reg;

    tpr_pkg::phase_t                 ph_base;
    tpr_pkg::phase_t                 ph_eff;
    logic [tpr_pkg::HDR_W-1:0]       bc_base;
    logic [tpr_pkg::ACC_W-1:0]       acc_base;
    logic [tpr_pkg::SEL_W-1:0]       comp_base;
    logic [tpr_pkg::CNT_W-1:0]       pc_base;
    logic [tpr_pkg::CHAR_W-1:0]      sel_base;
    logic [tpr_pkg::CHAR_W-1:0]      neg_sum;
    logic [tpr_pkg::CHAR_W-1:0]      value_low;
    logic [tpr_pkg::CHAR_W-1:0]      sel_upd;
    logic [tpr_pkg::CNT_W-1:0]       eff_count;
    logic                            is_last;
    logic                            emit;

    assign q_pop = !q_stat.empty && (!out_valid_reg || pixel_stream.ready);

    // A report start restarts every counter before the byte is parsed.
    assign ph_base   = q_entry.start ? tpr_pkg::PH_OFFSET : phase_reg;
    assign bc_base   = q_entry.start ? '0 : bc_reg;
    assign acc_base  = q_entry.start ? '0 : acc_reg;
    assign comp_base = q_entry.start ? '0 : comp_reg;
    assign pc_base   = q_entry.start ? '0 : pc_reg;
    assign sel_base  = q_entry.start ? '0 : sel_reg;

    assign ph_eff = (ph_base == tpr_pkg::PH_OFFSET && !(bc_base < cfg.header_offset)) ?
                    tpr_pkg::PH_SCAN1 : ph_base;

    assign neg_sum   = {acc_base[3:0], 4'h0} + q_entry.char_in - 8'd32;
    assign value_low = q_entry.is_digit ? {acc_base[3:0], q_entry.char_in[3:0]} :
                       (8'd0 - neg_sum);
    assign sel_upd   = (comp_base == cfg.channel_select) ? value_low : sel_base;

    always_comb
    begin
        eff_count = cfg.pixel_count;
        if (cfg.pixel_count == '0)
        begin
            eff_count = tpr_pkg::CNT_W'(1);
        end
        else if (cfg.pixel_count > tpr_pkg::CNT_W'(tpr_pkg::MAX_PIXELS))
        begin
            eff_count = tpr_pkg::CNT_W'(tpr_pkg::MAX_PIXELS);
        end
    end

    assign is_last = ({1'b0, pc_base} + 1'b1) >= {1'b0, eff_count};
    assign emit    = q_pop && ph_eff == tpr_pkg::PH_INT && !q_entry.is_high
                     && comp_base == tpr_pkg::COMP_LAST;

    // Next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (q_pop)
        begin
            case (ph_eff)
                tpr_pkg::PH_OFFSET: phase_next = tpr_pkg::PH_OFFSET;
                tpr_pkg::PH_SCAN1:
                begin
                    phase_next = q_entry.is_digit ? tpr_pkg::PH_SKIP3 : tpr_pkg::PH_SCAN1;
                end
                tpr_pkg::PH_SKIP3:
                begin
                    phase_next = (bc_base + 1'b1 >= 8'd3) ? tpr_pkg::PH_SCAN2 :
                                 tpr_pkg::PH_SKIP3;
                end
                tpr_pkg::PH_SCAN2:
                begin
                    phase_next = q_entry.is_digit ? tpr_pkg::PH_LEAD : tpr_pkg::PH_SCAN2;
                end
                tpr_pkg::PH_LEAD:   phase_next = tpr_pkg::PH_INT;
                tpr_pkg::PH_INT:
                begin
                    if (emit)
                    begin
                        phase_next = is_last ? tpr_pkg::PH_DONE : tpr_pkg::PH_LEAD;
                    end
                    else
                    begin
                        phase_next = tpr_pkg::PH_INT;
                    end
                end
                default:            phase_next = ph_eff;
            endcase
        end
    end

    // Datapath and output register
    always_comb
    begin
        bc_next        = bc_reg;
        acc_next       = acc_reg;
        comp_next      = comp_reg;
        pc_next        = pc_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !pixel_stream.ready;
        if (q_pop)
        begin
            bc_next   = bc_base;
            acc_next  = acc_base;
            comp_next = comp_base;
            pc_next   = pc_base;
            sel_next  = sel_base;
            case (ph_eff)
                tpr_pkg::PH_OFFSET: bc_next = bc_base + 1'b1;
                tpr_pkg::PH_SCAN1:
                begin
                    if (q_entry.is_digit)
                    begin
                        bc_next = '0;
                    end
                end
                tpr_pkg::PH_SKIP3:  bc_next = bc_base + 1'b1;
                tpr_pkg::PH_LEAD:
                begin
                    acc_next  = '0;
                    comp_next = '0;
                    sel_next  = '0;
                end
                tpr_pkg::PH_INT:
                begin
                    if (q_entry.is_high)
                    begin
                        acc_next = {acc_base[9:0], q_entry.char_in[5:0]};
                    end
                    else
                    begin
                        acc_next = '0;
                        if (emit)
                        begin
                            comp_next      = '0;
                            sel_next       = '0;
                            out_valid_next = 1'b1;
                            if (!is_last)
                            begin
                                pc_next = pc_base + 1'b1;
                            end
                        end
                        else
                        begin
                            comp_next = comp_base + 1'b1;
                            sel_next  = sel_upd;
                        end
                    end
                end
                default:
                begin
                    bc_next = bc_base;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tpr_pkg::PH_IDLE;
            bc_reg        <= '0;
            acc_reg       <= '0;
            comp_reg      <= '0;
            pc_reg        <= '0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bc_reg        <= bc_next;
            acc_reg       <= acc_next;
            comp_reg      <= comp_next;
            pc_reg        <= pc_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= sel_upd;
            out_index_reg <= pc_base[tpr_pkg::IDX_W-1:0];
            out_last_reg  <= is_last;
        end
    end

    assign pixel_stream.valid       = out_valid_reg;
    assign pixel_stream.pixel_value = out_value_reg;
    assign pixel_stream.pixel_index = out_index_reg;
    assign pixel_stream.last_pixel  = out_last_reg;

endmodule

[hdl/terminal_pixel_report_parser.sv]
// Top level of the pixel report parser: configuration registers and the three stages.
//
// Channels: char_stream takes one report byte per beat, with start_of_report
// set on the first byte of a report. pixel_stream gives one beat per decoded
// pixel: the selected colour component's low 8 bits, its index in the report
// and a flag on the final pixel. cfg writes channel_select (0), pixel_count
// (1) and header_offset (2); it is always ready, and a write is registered before the parser uses it.
// Throughput is one byte per cycle: the front end pushes each byte into a
// four-entry queue and the parser pops one byte a cycle whenever its output
// register is empty or being drained.
// A pixel appears on pixel_stream in the cycle after the parser pops the byte
// that ends its third component from the queue.
// Reset: the queue empties, the parser ignores bytes until a report starts,
// and the registers return to red, one pixel, no header offset.
// When the receiver stalls, the output register holds its pixel, the parser
// stops popping, and char_stream keeps taking bytes until the queue is full.
`include "terminal_pixel_report_parser_assert.svh"

module terminal_pixel_report_parser
(
    input  logic          clk,
    input  logic          rst_n,
    tpr_char_if.sink      char_stream,
    tpr_pixel_if.source   pixel_stream,
    tpr_cfg_if.sink       cfg
);

    tpr_pkg::cfg_t        cfg_reg;
    tpr_pkg::cfg_t        cfg_next;
    tpr_pkg::q_stat_t     q_stat;
    tpr_pkg::q_entry_t    q_wr_entry;
    tpr_pkg::q_entry_t    q_rd_entry;
    logic                 q_push;
    logic                 q_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                tpr_pkg::REG_CHANNEL_SELECT: cfg_next.channel_select = cfg.data[1:0];
                tpr_pkg::REG_PIXEL_COUNT:    cfg_next.pixel_count    = cfg.data;
                tpr_pkg::REG_HEADER_OFFSET:  cfg_next.header_offset  = cfg.data[7:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_select <= '0;
            cfg_reg.pixel_count    <= tpr_pkg::CNT_W'(1);
            cfg_reg.header_offset  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpr_front u_front
    (
        .char_stream (char_stream),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_entry     (q_wr_entry)
    );

    tpr_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .stat     (q_stat)
    );

    tpr_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_entry      (q_rd_entry),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .pixel_stream (pixel_stream)
    );

    `TPR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty)
    `TPR_ASSERT_NOW(a_count_bound, 1'b1, q_stat.count <= tpr_pkg::Q_CNT_W'(tpr_pkg::Q_DEPTH))
    `TPR_ASSERT_NEXT(a_fill_to_full,
        q_push && !q_pop && q_stat.count == tpr_pkg::Q_CNT_W'(tpr_pkg::Q_DEPTH - 1),
        q_stat.full)

endmodule
